### hw/rtl/mvna_pkg.sv
package mvna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int CFG_W = 11;
    localparam int IDX_W = 10;
    localparam int ACC_W = 48;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_FACE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_CMD   = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [IDX_W-1:0]  vertex_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [IDX_W-1:0]  corner_a;
        logic [IDX_W-1:0]  corner_b;
        logic [IDX_W-1:0]  corner_c;
    } cmd_item_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [1:0]         status;
    } res_item_t;

endpackage

### hw/rtl/mesh_vertex_normal_accumulator_top.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------
// command   | start / busy         | cmd_item (cmd_item_t)
// result    | done strobe          | result (res_item_t)
// config    | cfg_valid / cfg_ready| cfg_data (vertex_count, 11 bits)
//
// busy covers the whole item: invalid and out-of-range items go straight to done;
// faces do three position reads, six products through one shared multiplier and
// three read-modify-write passes; reads do a length scan, three squares, a 32-step
// square root and three 47-step restoring divides, and a zero sum skips the rest.
// done strobes in the cycle busy drops; the receiver cannot stall.
// Reset clears control only; memories hold no reset value.
module mesh_vertex_normal_accumulator_top
    import mvna_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_item_t         cmd_item,
    output logic              done,
    output res_item_t         result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_LOAD, S_FRD, S_FRW, S_FDIFF, S_FMUL, S_FMWAIT,
        S_ARD, S_AWAIT, S_AWR, S_RRD, S_RWAIT, S_RMAG, S_RLEN, S_RSHIFT,
        S_RSQ, S_RSQW, S_SQRT, S_DIVI, S_DIV, S_DIVF, S_OUT
    } state_t;

    logic [ACC_W-1:0] pos_mem [MAX_VERTICES];
    logic signed [ACC_W-1:0] acx_mem [MAX_VERTICES];
    logic signed [ACC_W-1:0] acy_mem [MAX_VERTICES];
    logic signed [ACC_W-1:0] acz_mem [MAX_VERTICES];

    state_t state_reg;
    logic [CFG_W-1:0] vcount_reg;
    cmd_item_t item_reg;
    res_item_t res_reg;
    logic done_reg;
    logic [1:0] cnt_reg;
    logic [3:0] mcnt_reg;
    logic [5:0] step_reg;
    logic [AW-1:0] raddr_reg, waddr;
    logic [ACC_W-1:0] prd_reg;
    logic signed [ACC_W-1:0] arx_reg, ary_reg, arz_reg;
    logic signed [15:0] p0_reg [3];
    logic signed [15:0] p1_reg [3];
    logic signed [15:0] p2_reg [3];
    logic signed [16:0] u_reg [3];
    logic signed [16:0] w_reg [3];
    logic signed [34:0] prod_reg;
    logic signed [35:0] n_reg [3];
    logic signed [ACC_W-1:0] sum_reg [3];
    logic [47:0] b_reg [3];
    logic sgn_reg [3];
    logic [5:0] len_reg;
    logic [63:0] s_reg, rem_reg, bit_reg, res_sq_reg;
    logic [31:0] r_reg;
    logic [46:0] num_reg;
    logic [31:0] q_reg;
    logic [31:0] drem_reg;
    logic [1:0] lane_reg;
    logic signed [15:0] nout_reg [3];

    logic [16:0] lim;
    logic [16:0] idx_ext [3];
    logic in_rng;
    logic [AW-1:0] cidx;
    logic signed [16:0] ma, mb;
    logic signed [34:0] mprod;
    logic [31:0] sqa;
    logic [63:0] sqp;
    logic [63:0] trial;
    logic [32:0] dtrial;
    logic signed [ACC_W:0] asum;
    logic signed [ACC_W-1:0] asat;
    logic signed [ACC_W-1:0] aold;
    logic mem_we;

    assign cfg_ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = res_reg;

    assign lim = ({6'd0, vcount_reg} < MAXV) ? {6'd0, vcount_reg} : MAXV;
    assign idx_ext[0] = 17'(item_reg.corner_a);
    assign idx_ext[1] = 17'(item_reg.corner_b);
    assign idx_ext[2] = 17'(item_reg.corner_c);

    always_comb
    begin
        case (item_reg.cmd)
            CMD_FACE: in_rng = (idx_ext[0] < lim) && (idx_ext[1] < lim)
                               && (idx_ext[2] < lim);
            default:  in_rng = 17'(item_reg.vertex_index) < lim;
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            2'd0:    cidx = AW'(item_reg.corner_a);
            2'd1:    cidx = AW'(item_reg.corner_b);
            default: cidx = AW'(item_reg.corner_c);
        endcase
    end

    // shared multiplier: cross products on faces
    always_comb
    begin
        case (mcnt_reg)
            4'd0:    begin ma = u_reg[1]; mb = w_reg[2]; end
            4'd1:    begin ma = u_reg[2]; mb = w_reg[1]; end
            4'd2:    begin ma = u_reg[2]; mb = w_reg[0]; end
            4'd3:    begin ma = u_reg[0]; mb = w_reg[2]; end
            4'd4:    begin ma = u_reg[0]; mb = w_reg[1]; end
            default: begin ma = u_reg[1]; mb = w_reg[0]; end
        endcase
    end
    assign mprod = ma * mb;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    sqa = b_reg[0][31:0];
            2'd1:    sqa = b_reg[1][31:0];
            default: sqa = b_reg[2][31:0];
        endcase
    end
    assign sqp = sqa * sqa;

    assign trial = res_sq_reg + bit_reg;
    assign dtrial = {drem_reg, num_reg[46]} - {1'b0, r_reg};

    always_comb
    begin
        case (cnt_reg)
            2'd0:    begin aold = arx_reg; end
            2'd1:    begin aold = ary_reg; end
            default: begin aold = arz_reg; end
        endcase
    end

    always_comb
    begin
        logic signed [35:0] nv;
        case (cnt_reg)
            2'd0:    nv = n_reg[0];
            2'd1:    nv = n_reg[1];
            default: nv = n_reg[2];
        endcase
        asum = {aold[ACC_W-1], aold} + (ACC_W+1)'(nv);
        if (asum[ACC_W] != asum[ACC_W-1])
            asat = asum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            asat = asum[ACC_W-1:0];
    end

    assign mem_we = (state_reg == S_AWR);
    assign waddr = raddr_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && in_rng)
        begin
            pos_mem[AW'(item_reg.vertex_index)] <= {item_reg.pos_z, item_reg.pos_y,
                                                     item_reg.pos_x};
            acx_mem[AW'(item_reg.vertex_index)] <= '0;
            acy_mem[AW'(item_reg.vertex_index)] <= '0;
            acz_mem[AW'(item_reg.vertex_index)] <= '0;
        end
        else if (mem_we)
        begin
            case (cnt_reg)
                2'd0:    acx_mem[waddr] <= asat;
                2'd1:    acy_mem[waddr] <= asat;
                default: acz_mem[waddr] <= asat;
            endcase
        end
        prd_reg <= pos_mem[raddr_reg];
        arx_reg <= acx_mem[raddr_reg];
        ary_reg <= acy_mem[raddr_reg];
        arz_reg <= acz_mem[raddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcount_reg <= '0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            mcnt_reg <= '0;
            step_reg <= '0;
            lane_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                        vcount_reg <= cfg_data;
                    if (start)
                    begin
                        item_reg <= cmd_item;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    res_reg.normal_x <= '0;
                    res_reg.normal_y <= '0;
                    res_reg.normal_z <= '0;
                    cnt_reg <= '0;
                    mcnt_reg <= '0;
                    if (item_reg.cmd == CMD_LOAD || item_reg.cmd == CMD_FACE
                        || item_reg.cmd == CMD_READ)
                    begin
                        if (!in_rng)
                        begin
                            res_reg.status <= ST_RANGE;
                            state_reg <= S_OUT;
                        end
                        else if (item_reg.cmd == CMD_LOAD)
                        begin
                            res_reg.status <= ST_OK;
                            state_reg <= S_LOAD;
                        end
                        else if (item_reg.cmd == CMD_FACE)
                        begin
                            res_reg.status <= ST_OK;
                            raddr_reg <= AW'(item_reg.corner_a);
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            res_reg.status <= ST_OK;
                            raddr_reg <= AW'(item_reg.vertex_index);
                            state_reg <= S_RRD;
                        end
                    end
                    else
                    begin
                        res_reg.status <= ST_CMD;
                        state_reg <= S_OUT;
                    end
                end
                S_LOAD: state_reg <= S_OUT;
                S_FRD: state_reg <= S_FRW;
                S_FRW:
                begin
                    case (cnt_reg)
                        2'd0:
                        begin
                            p0_reg[0] <= prd_reg[15:0];
                            p0_reg[1] <= prd_reg[31:16];
                            p0_reg[2] <= prd_reg[47:32];
                        end
                        2'd1:
                        begin
                            p1_reg[0] <= prd_reg[15:0];
                            p1_reg[1] <= prd_reg[31:16];
                            p1_reg[2] <= prd_reg[47:32];
                        end
                        default:
                        begin
                            p2_reg[0] <= prd_reg[15:0];
                            p2_reg[1] <= prd_reg[31:16];
                            p2_reg[2] <= prd_reg[47:32];
                        end
                    endcase
                    if (cnt_reg == 2'd2)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_FDIFF;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 2'd1;
                        raddr_reg <= (cnt_reg == 2'd0) ? AW'(item_reg.corner_b)
                                                       : AW'(item_reg.corner_c);
                        state_reg <= S_FRD;
                    end
                end
                S_FDIFF:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        u_reg[k] <= 17'(p1_reg[k]) - 17'(p0_reg[k]);
                        w_reg[k] <= 17'(p2_reg[k]) - 17'(p0_reg[k]);
                    end
                    state_reg <= S_FMUL;
                end
                S_FMUL:
                begin
                    prod_reg <= mprod;
                    state_reg <= S_FMWAIT;
                end
                S_FMWAIT:
                begin
                    if (!mcnt_reg[0])
                        n_reg[mcnt_reg[2:1]] <= 36'(prod_reg);
                    else
                        n_reg[mcnt_reg[2:1]] <= n_reg[mcnt_reg[2:1]] - 36'(prod_reg);
                    if (mcnt_reg == 4'd5)
                    begin
                        cnt_reg <= '0;
                        lane_reg <= '0;
                        raddr_reg <= AW'(item_reg.corner_a);
                        state_reg <= S_ARD;
                    end
                    else
                    begin
                        mcnt_reg <= mcnt_reg + 4'd1;
                        state_reg <= S_FMUL;
                    end
                end
                S_ARD: state_reg <= S_AWAIT;
                S_AWAIT:
                begin
                    cnt_reg <= '0;
                    state_reg <= S_AWR;
                end
                S_AWR:
                begin
                    // one axis per cycle; read the next corner after this one's three writes
                    if (cnt_reg == 2'd2)
                    begin
                        if (lane_reg == 2'd2)
                            state_reg <= S_OUT;
                        else
                        begin
                            lane_reg <= lane_reg + 2'd1;
                            raddr_reg <= (lane_reg == 2'd0) ? AW'(item_reg.corner_b)
                                                            : AW'(item_reg.corner_c);
                            state_reg <= S_ARD;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + 2'd1;
                end
                S_RRD: state_reg <= S_RWAIT;
                S_RWAIT:
                begin
                    sum_reg[0] <= arx_reg;
                    sum_reg[1] <= ary_reg;
                    sum_reg[2] <= arz_reg;
                    state_reg <= S_RMAG;
                end
                S_RMAG:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        sgn_reg[k] <= sum_reg[k][ACC_W-1];
                        b_reg[k] <= sum_reg[k][ACC_W-1] ? 48'(-sum_reg[k]) : sum_reg[k];
                    end
                    len_reg <= '0;
                    step_reg <= 6'd48;
                    state_reg <= S_RLEN;
                end
                S_RLEN:
                begin
                    // scan bit length of the OR of magnitudes, one bit a cycle
                    if (step_reg == 6'd0)
                    begin
                        if ((b_reg[0] | b_reg[1] | b_reg[2]) == '0)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_RSHIFT;
                    end
                    else
                    begin
                        if (((b_reg[0] | b_reg[1] | b_reg[2]) >> (step_reg - 6'd1)) != '0
                            && len_reg == 6'd0)
                            len_reg <= step_reg;
                        step_reg <= step_reg - 6'd1;
                    end
                end
                S_RSHIFT:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (len_reg <= 6'd30)
                            b_reg[k] <= b_reg[k] << (6'd30 - len_reg);
                        else
                            b_reg[k] <= b_reg[k] >> (len_reg - 6'd30);
                    end
                    s_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_RSQ;
                end
                S_RSQ:
                begin
                    s_reg <= s_reg + sqp;
                    if (cnt_reg == 2'd2)
                        state_reg <= S_RSQW;
                    else
                        cnt_reg <= cnt_reg + 2'd1;
                end
                S_RSQW:
                begin
                    rem_reg <= s_reg;
                    res_sq_reg <= '0;
                    bit_reg <= 64'd1 << 62;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        r_reg <= res_sq_reg[31:0];
                        lane_reg <= '0;
                        state_reg <= S_DIVI;
                    end
                    else
                    begin
                        if (rem_reg >= trial)
                        begin
                            rem_reg <= rem_reg - trial;
                            res_sq_reg <= (res_sq_reg >> 1) + bit_reg;
                        end
                        else
                            res_sq_reg <= res_sq_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIVI:
                begin
                    num_reg <= ({b_reg[lane_reg][32:0], 14'd0}) + 47'(r_reg >> 1);
                    drem_reg <= '0;
                    q_reg <= '0;
                    step_reg <= 6'd47;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!dtrial[32])
                    begin
                        drem_reg <= dtrial[31:0];
                        q_reg <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= {drem_reg[30:0], num_reg[46]};
                        q_reg <= {q_reg[30:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                    step_reg <= step_reg - 6'd1;
                    if (step_reg == 6'd1)
                        state_reg <= S_DIVF;
                end
                S_DIVF:
                begin
                    nout_reg[lane_reg] <= sgn_reg[lane_reg] ? -q_reg[15:0] : q_reg[15:0];
                    if (lane_reg == 2'd2)
                    begin
                        res_reg.normal_x <= nout_reg[0];
                        res_reg.normal_y <= nout_reg[1];
                        res_reg.normal_z <= sgn_reg[2] ? -q_reg[15:0] : q_reg[15:0];
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        lane_reg <= lane_reg + 2'd1;
                        state_reg <= S_DIVI;
                    end
                end
                S_OUT:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("done outside idle");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than a cycle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= ST_CMD) else $error("bad status");
`endif

endmodule
